// ----- sv/lzwd_pkg.sv -----
// shared types and constants for the lzw code decoder
// no dependencies; every other file except lzwd_ram refers to it by scoped names
`default_nettype none

package lzwd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 12;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CMP_W   = 17;
  localparam int unsigned LIT_NUM = 256;

  localparam logic [CFG_W-1:0]  CFG_RST  = 12'd4095;
  localparam logic [BYTE_W-1:0] LIT_FLIP = 8'h80;

  // request from the dictionary walker to the output stage
  typedef struct packed {
    logic go;
    logic err;
    logic ovf;
  } emit_req_t;

endpackage

`default_nettype wire

// ----- sv/lzwd_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/lzwd_walk.sv -----
// input side: code check, dictionary chain walk, dictionary update, max_code register
// depends on lzwd_pkg; drives the dictionary ram and the write port of the byte stack
`default_nettype none

module lzwd_walk #(
  parameter int unsigned CODE_BITS = 12,
  parameter int unsigned MAX_RUN   = 64,
  localparam int unsigned CW   = CODE_BITS,
  localparam int unsigned DW   = CODE_BITS + lzwd_pkg::BYTE_W,
  localparam int unsigned PW   = $clog2(MAX_RUN),
  localparam int unsigned CNTW = $clog2(MAX_RUN + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [lzwd_pkg::CODE_W-1:0]       code_i,
  input  wire logic                              start_req_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [lzwd_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                                   dict_we_o,
  output logic      [CW-1:0]                     dict_waddr_o,
  output logic      [DW-1:0]                     dict_wdata_o,
  output logic                                   dict_re_o,
  output logic      [CW-1:0]                     dict_raddr_o,
  input  wire logic [DW-1:0]                     dict_rdata_i,
  output logic                                   stk_we_o,
  output logic      [PW-1:0]                     stk_waddr_o,
  output logic      [lzwd_pkg::BYTE_W-1:0]       stk_wdata_o,
  output lzwd_pkg::emit_req_t                    emit_o,
  output logic      [CNTW-1:0]                   emit_cnt_o,
  output logic      [PW-1:0]                     emit_top_o,
  input  wire logic                              emit_idle_i
);

  localparam int unsigned NFW = CODE_BITS + 1;
  localparam logic [CW-1:0]   LIT_TOP  = CW'(lzwd_pkg::LIT_NUM);
  localparam logic [NFW-1:0]  NF_RST   = NFW'(lzwd_pkg::LIT_NUM);
  localparam logic [PW-1:0]   PTR_LAST = PW'(MAX_RUN - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(MAX_RUN);
  localparam logic [lzwd_pkg::CMP_W-1:0] MASK_C = lzwd_pkg::CMP_W'((1 << CODE_BITS) - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ROOT,
    S_POP
  } state_e;

  state_e                      state_q, state_d;
  logic [CW-1:0]               cur_q, cur_d;
  logic [CW-1:0]               code_q, code_d;
  logic [PW-1:0]               wptr_q, wptr_d;
  logic [CNTW-1:0]             cnt_q, cnt_d;
  logic                        ovf_q, ovf_d;
  logic                        add_q, add_d;
  logic [NFW-1:0]              next_free_q, next_free_d;
  logic [CW-1:0]               prior_code_q, prior_code_d;
  logic [lzwd_pkg::BYTE_W-1:0] prior_first_q, prior_first_d;
  logic                        have_prior_q, have_prior_d;
  logic [lzwd_pkg::CFG_W-1:0]  max_code_q;

  logic [CW-1:0]               code_w, root, rd_prefix;
  logic [lzwd_pkg::BYTE_W-1:0] rd_byte, lit;
  logic [NFW-1:0]              nf_eff;
  logic                        hp_eff, can_add, is_kw, undef, accept;
  logic [lzwd_pkg::CMP_W-1:0]  lim_c, nf_c, code_c;
  logic [PW-1:0]               wptr_inc;
  logic [CNTW-1:0]             cnt_inc;
  logic                        ovf_inc;

  assign code_w    = CW'(code_i);
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign nf_eff    = start_req_i ? NF_RST : next_free_q;
  assign hp_eff    = start_req_i ? 1'b0 : have_prior_q;
  assign lim_c     = (lzwd_pkg::CMP_W'(max_code_q) > MASK_C) ? MASK_C
                                                            : lzwd_pkg::CMP_W'(max_code_q);
  assign nf_c      = lzwd_pkg::CMP_W'(nf_eff);
  assign code_c    = lzwd_pkg::CMP_W'(code_w);
  assign can_add   = nf_c <= lim_c;
  assign is_kw     = hp_eff && (code_c == nf_c);
  assign undef     = hp_eff ? !((code_c < nf_c) || (is_kw && can_add))
                            : (code_w >= LIT_TOP);
  // a code one past the table decodes from the previous string
  assign root      = is_kw ? prior_code_q : code_w;

  assign rd_prefix = dict_rdata_i[DW-1:lzwd_pkg::BYTE_W];
  assign rd_byte   = dict_rdata_i[lzwd_pkg::BYTE_W-1:0];
  assign lit       = cur_q[lzwd_pkg::BYTE_W-1:0] ^ lzwd_pkg::LIT_FLIP;

  // the stack wraps, so after an overlong walk it keeps the leading bytes
  assign wptr_inc  = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
  assign cnt_inc   = (cnt_q == CNT_FULL) ? cnt_q : cnt_q + 1'b1;
  assign ovf_inc   = ovf_q || (cnt_q == CNT_FULL);

  assign in_stall_o   = (state_q != S_IDLE);
  assign emit_cnt_o   = cnt_inc;
  assign emit_top_o   = wptr_q;
  assign dict_waddr_o = next_free_q[CW-1:0];
  assign dict_wdata_o = {prior_code_q, lit};

  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    code_d        = code_q;
    wptr_d        = wptr_q;
    cnt_d         = cnt_q;
    ovf_d         = ovf_q;
    add_d         = add_q;
    next_free_d   = next_free_q;
    prior_code_d  = prior_code_q;
    prior_first_d = prior_first_q;
    have_prior_d  = have_prior_q;
    dict_we_o     = 1'b0;
    dict_re_o     = 1'b0;
    dict_raddr_o  = root;
    stk_we_o      = 1'b0;
    stk_waddr_o   = wptr_q;
    stk_wdata_o   = rd_byte;
    emit_o        = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          next_free_d  = nf_eff;
          have_prior_d = hp_eff;
          if (undef) begin
            emit_o.go  = 1'b1;
            emit_o.err = 1'b1;
            state_d    = S_POP;
          end else begin
            code_d = code_w;
            add_d  = hp_eff && can_add;
            cur_d  = root;
            ovf_d  = 1'b0;
            if (is_kw) begin
              stk_we_o    = 1'b1;
              stk_waddr_o = '0;
              stk_wdata_o = prior_first_q;
              wptr_d      = PW'(1);
              cnt_d       = CNTW'(1);
            end else begin
              wptr_d = '0;
              cnt_d  = '0;
            end
            if (root >= LIT_TOP) begin
              dict_re_o = 1'b1;
              state_d   = S_WALK;
            end else begin
              state_d = S_ROOT;
            end
          end
        end
      end
      S_WALK: begin
        stk_we_o = 1'b1;
        wptr_d   = wptr_inc;
        cnt_d    = cnt_inc;
        ovf_d    = ovf_inc;
        if (rd_prefix >= LIT_TOP) begin
          dict_re_o    = 1'b1;
          dict_raddr_o = rd_prefix;
        end else begin
          cur_d   = rd_prefix;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        stk_we_o      = 1'b1;
        stk_wdata_o   = lit;
        emit_o.go     = 1'b1;
        emit_o.ovf    = ovf_inc;
        dict_we_o     = add_q;
        if (add_q) begin
          next_free_d = next_free_q + 1'b1;
        end
        prior_code_d  = code_q;
        prior_first_d = lit;
        have_prior_d  = 1'b1;
        state_d       = S_POP;
      end
      S_POP: begin
        if (emit_idle_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      next_free_q   <= NF_RST;
      prior_code_q  <= '0;
      prior_first_q <= '0;
      have_prior_q  <= 1'b0;
      max_code_q    <= lzwd_pkg::CFG_RST;
      wptr_q        <= '0;
      cnt_q         <= '0;
      ovf_q         <= 1'b0;
      add_q         <= 1'b0;
    end else begin
      state_q       <= state_d;
      next_free_q   <= next_free_d;
      prior_code_q  <= prior_code_d;
      prior_first_q <= prior_first_d;
      have_prior_q  <= have_prior_d;
      wptr_q        <= wptr_d;
      cnt_q         <= cnt_d;
      ovf_q         <= ovf_d;
      add_q         <= add_d;
      if (cfg_we_i) begin
        max_code_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    code_q <= code_d;
  end

endmodule

`default_nettype wire

// ----- sv/lzwd_emit.sv -----
// output side: pops the byte stack newest first into the output register
// depends on lzwd_pkg; reads the byte stack ram
`default_nettype none

module lzwd_emit #(
  parameter int unsigned MAX_RUN = 64,
  localparam int unsigned PW   = $clog2(MAX_RUN),
  localparam int unsigned CNTW = $clog2(MAX_RUN + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lzwd_pkg::emit_req_t         req_i,
  input  wire logic [CNTW-1:0]             cnt_i,
  input  wire logic [PW-1:0]               top_i,
  output logic                             idle_o,
  output logic                             stk_re_o,
  output logic      [PW-1:0]               stk_raddr_o,
  input  wire logic [lzwd_pkg::BYTE_W-1:0] stk_rdata_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [lzwd_pkg::BYTE_W-1:0] out_byte_o,
  output logic                             last_o,
  output logic                             error_o
);

  localparam logic [PW-1:0]   PTR_LAST = PW'(MAX_RUN - 1);
  localparam logic [CNTW-1:0] CNT_ONE  = CNTW'(1);

  logic                        busy_q, err_q, pend_q, out_valid_q;
  logic [CNTW-1:0]             rem_q;
  logic [PW-1:0]               rptr_q;
  logic                        ovf_q, pend_last_q, pend_err_q;
  logic [lzwd_pkg::BYTE_W-1:0] out_byte_q;
  logic                        out_last_q, out_err_q;

  logic out_free, issue, load_pend, load_err;

  assign out_free  = !out_valid_q || !out_stall_i;
  // the pending stack word may be replaced in the cycle it moves out
  assign issue     = busy_q && (rem_q != '0) && (!pend_q || out_free);
  assign load_pend = pend_q && out_free;
  assign load_err  = err_q && out_free;

  assign stk_re_o    = issue;
  assign stk_raddr_o = rptr_q;
  assign idle_o      = !busy_q && !err_q;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;
  assign error_o     = out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      err_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      rptr_q      <= '0;
    end else begin
      if (req_i.go) begin
        busy_q <= !req_i.err;
        err_q  <= req_i.err;
        rem_q  <= cnt_i;
        rptr_q <= top_i;
      end else begin
        if (issue) begin
          rem_q  <= rem_q - 1'b1;
          rptr_q <= (rptr_q == '0) ? PTR_LAST : rptr_q - 1'b1;
        end
        if (busy_q && (rem_q == '0) && !pend_q) begin
          busy_q <= 1'b0;
        end
        if (load_err) begin
          err_q <= 1'b0;
        end
      end
      if (issue) begin
        pend_q <= 1'b1;
      end else if (load_pend) begin
        pend_q <= 1'b0;
      end
      if (load_pend || load_err) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      ovf_q <= req_i.ovf;
    end
    if (issue) begin
      pend_last_q <= (rem_q == CNT_ONE);
      pend_err_q  <= (rem_q == CNT_ONE) && ovf_q;
    end
    if (load_pend) begin
      out_byte_q <= stk_rdata_i;
      out_last_q <= pend_last_q;
      out_err_q  <= pend_err_q;
    end else if (load_err) begin
      out_byte_q <= '0;
      out_last_q <= 1'b1;
      out_err_q  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lzw_code_decoder_top.sv -----
// lzw code decoder: one compressed code in, the bytes of its string out
// depends on lzwd_pkg, lzwd_ram, lzwd_walk and lzwd_emit
//
// input channel: in_valid_i / in_stall_o with code_i and start_req_i; an item is taken
// at a clock edge with valid high and stall low. start_req_i clears the dictionary
// before the code is decoded. max_code is written through cfg_we_i / cfg_wdata_i; the user
// must do so only while the block is idle, which the block itself does not enforce.
// output channel: out_valid_o / out_stall_i with out_byte_o, last_o, error_o; one item
// per decoded byte, first byte first, last_o on the final one. an undefined code gives
// a single item with byte 0 and error_o set; a string longer than MAX_RUN is cut to
// MAX_RUN bytes with error_o on the last.
// decoding: the prefix chain of a code is walked with one dictionary read per entry
// (the read latency of the dictionary ram sets that loop), the root literal is written
// to the stack, then the stack is read once per byte out. a code one past the table
// starts its stack with the first byte of the previous string. the input stalls until
// the last byte of an item sits in the output register; that byte may wait there while
// the next code is taken.
// reset: dictionary empty, max_code 4095, output empty; the rams need no clearing.
// a stalled receiver holds the output register and pauses the stack reads.
`default_nettype none

module lzw_code_decoder_top #(
  parameter int unsigned CODE_BITS = 12,
  parameter int unsigned MAX_RUN   = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [lzwd_pkg::CODE_W-1:0]       code_i,
  input  wire logic                              start_req_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [lzwd_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [lzwd_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                                   last_o,
  output logic                                   error_o
);

  localparam int unsigned CW   = CODE_BITS;
  localparam int unsigned DW   = CODE_BITS + lzwd_pkg::BYTE_W;
  localparam int unsigned PW   = $clog2(MAX_RUN);
  localparam int unsigned CNTW = $clog2(MAX_RUN + 1);

  logic                        dict_we, dict_re;
  logic [CW-1:0]               dict_waddr, dict_raddr;
  logic [DW-1:0]               dict_wdata, dict_rdata;
  logic                        stk_we, stk_re;
  logic [PW-1:0]               stk_waddr, stk_raddr;
  logic [lzwd_pkg::BYTE_W-1:0] stk_wdata, stk_rdata;
  lzwd_pkg::emit_req_t         emit_req;
  logic [CNTW-1:0]             emit_cnt;
  logic [PW-1:0]               emit_top;
  logic                        emit_idle;

  lzwd_ram #(
    .WIDTH (DW),
    .DEPTH (1 << CODE_BITS)
  ) u_dict_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (dict_waddr),
    .wdata_i (dict_wdata),
    .re_i    (dict_re),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  lzwd_ram #(
    .WIDTH (lzwd_pkg::BYTE_W),
    .DEPTH (MAX_RUN)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  lzwd_walk #(
    .CODE_BITS (CODE_BITS),
    .MAX_RUN   (MAX_RUN)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_i       (code_i),
    .start_req_i  (start_req_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .dict_we_o    (dict_we),
    .dict_waddr_o (dict_waddr),
    .dict_wdata_o (dict_wdata),
    .dict_re_o    (dict_re),
    .dict_raddr_o (dict_raddr),
    .dict_rdata_i (dict_rdata),
    .stk_we_o     (stk_we),
    .stk_waddr_o  (stk_waddr),
    .stk_wdata_o  (stk_wdata),
    .emit_o       (emit_req),
    .emit_cnt_o   (emit_cnt),
    .emit_top_o   (emit_top),
    .emit_idle_i  (emit_idle)
  );

  lzwd_emit #(
    .MAX_RUN (MAX_RUN)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (emit_req),
    .cnt_i       (emit_cnt),
    .top_i       (emit_top),
    .idle_o      (emit_idle),
    .stk_re_o    (stk_re),
    .stk_raddr_o (stk_raddr),
    .stk_rdata_i (stk_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule

`default_nettype wire

// ----- sv/lzwd_checker.sv -----
// port-level checks for the lzw code decoder, bound to the top level
// depends on lzwd_pkg and lzw_code_decoder_top
`default_nettype none

module lzwd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [lzwd_pkg::BYTE_W-1:0] out_byte_o,
  input wire logic                        last_o,
  input wire logic                        error_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
                                   && $stable(last_o) && $stable(error_o))
    else $error("stalled output item changed");

  // an error always ends the run of bytes for a code
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o)
    else $error("error flagged on a byte that is not last");

  // the block comes out of reset ready and empty
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !in_stall_o && !out_valid_o)
    else $error("block not idle after reset");

  // one code at a time: a taken item stalls the input
  a_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  // mid-string the next code is never taken
  a_run_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input open while a string is still being emitted");

endmodule

bind lzw_code_decoder_top lzwd_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o),
  .error_o     (error_o)
);

`default_nettype wire

// ----- tb/lzw_code_decoder_top_test.sv -----
// self-checking bench for lzw_code_decoder_top: directed codes, kwkwk chains and random streams
// decoded bytes are checked against an in-bench dictionary model or hand-written values, over several max_code settings
// depends on lzwd_pkg and the decoder rtl only
`timescale 1ns / 100ps

module lzw_code_decoder_top_test;

  localparam int unsigned MAX_RUN     = 64;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned DRAIN       = 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned N_DIR       = 20;
  localparam int unsigned TABLE_DEPTH = 4096;

  typedef struct packed {
    logic [lzwd_pkg::BYTE_W-1:0] value;
    logic                        last;
    logic                        err;
  } dec_byte_t;

  // one code item, with a hand-written single-byte expectation where typed is set
  typedef struct packed {
    logic [lzwd_pkg::CODE_W-1:0] code;
    logic                        start;
    logic                        typed;
    logic [lzwd_pkg::BYTE_W-1:0] value;
    logic                        err;
  } code_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic [lzwd_pkg::CODE_W-1:0] code_in = '0;
  logic                        start_in = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [lzwd_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                        out_stall = 1'b0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [lzwd_pkg::BYTE_W-1:0] out_byte_o;
  logic                        last_o;
  logic                        error_o;

  // dictionary model state
  logic [lzwd_pkg::CODE_W-1:0] dict_prefix [TABLE_DEPTH];
  logic [lzwd_pkg::BYTE_W-1:0] dict_byte [TABLE_DEPTH];
  logic [lzwd_pkg::CODE_W:0]   dict_next = 13'(lzwd_pkg::LIT_NUM);
  logic [lzwd_pkg::CFG_W-1:0]  dict_limit = lzwd_pkg::CFG_RST;
  logic [lzwd_pkg::CODE_W-1:0] prev_code = '0;
  logic [lzwd_pkg::BYTE_W-1:0] prev_first = '0;
  logic                        prev_valid = 1'b0;

  dec_byte_t   step_bytes [$];
  dec_byte_t   pending_bytes [$];
  code_row_t   dir_rows [N_DIR];
  int unsigned idle_pct = 7;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  int unsigned fails = 0;
  int unsigned codes_sent = 0;
  int unsigned bytes_seen = 0;
  int unsigned bad_codes = 0;
  int unsigned cut_strings = 0;
  int unsigned cycle_cnt = 0;
  logic [lzwd_pkg::CFG_W-1:0] mid_limit;

  lzw_code_decoder_top #(
    .CODE_BITS(12),
    .MAX_RUN  (MAX_RUN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .code_i     (code_in),
    .start_req_i(start_in),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // expected bytes for one code; updates the dictionary model as the block would
  function automatic void decode_code(input logic [lzwd_pkg::CODE_W-1:0] c, input logic s);
    logic [lzwd_pkg::BYTE_W-1:0] str [$];
    logic [lzwd_pkg::CODE_W-1:0] walk;
    logic                        kw;
    logic                        bad;
    int unsigned                 n;
    dec_byte_t                   item;
    step_bytes.delete();
    if (s) begin
      dict_next  = 13'(lzwd_pkg::LIT_NUM);
      prev_valid = 1'b0;
    end
    if (!prev_valid) begin
      bad = (c >= lzwd_pkg::LIT_NUM);
    end else begin
      bad = !(({1'b0, c} < dict_next) ||
              ({1'b0, c} == dict_next && dict_next <= {1'b0, dict_limit}));
    end
    if (bad) begin
      item = '{value: '0, last: 1'b1, err: 1'b1};
      step_bytes.insert(step_bytes.size(), item);
      bad_codes++;
      return;
    end
    // the code one past the table repeats the previous string plus its first byte
    kw   = prev_valid && ({1'b0, c} == dict_next);
    walk = kw ? prev_code : c;
    for (int g = 0; g < TABLE_DEPTH && walk >= lzwd_pkg::LIT_NUM; g++) begin
      str.push_front(dict_byte[walk]);
      walk = dict_prefix[walk];
    end
    str.push_front(walk[lzwd_pkg::BYTE_W-1:0] ^ lzwd_pkg::LIT_FLIP);
    if (kw) str.insert(str.size(), prev_first);
    if (prev_valid && dict_next <= {1'b0, dict_limit}) begin
      dict_prefix[dict_next[lzwd_pkg::CODE_W-1:0]] = prev_code;
      dict_byte[dict_next[lzwd_pkg::CODE_W-1:0]]   = str[0];
      dict_next++;
    end
    prev_code  = c;
    prev_first = str[0];
    prev_valid = 1'b1;
    n = (str.size() > MAX_RUN) ? MAX_RUN : str.size();
    if (str.size() > MAX_RUN) cut_strings++;
    for (int k = 0; k < n; k++) begin
      item = '{value: str[k], last: (k + 1 == n),
               err: (k + 1 == n) && (str.size() > MAX_RUN)};
      step_bytes.insert(step_bytes.size(), item);
    end
  endfunction

  // hold the item until taken, then queue what it should decode to
  task automatic offer_code(input code_row_t row);
    dec_byte_t item;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    code_in  <= row.code;
    start_in <= row.start;
    do @(posedge clk_i); while (in_stall_o);
    decode_code(row.code, row.start);
    codes_sent++;
    if (row.typed) begin
      item = '{value: row.value, last: 1'b1, err: row.err};
      pending_bytes.insert(pending_bytes.size(), item);
    end else begin
      foreach (step_bytes[i]) pending_bytes.insert(pending_bytes.size(), step_bytes[i]);
    end
  endtask

  // mostly well-formed streams: literals, known entries and the next free code
  task automatic send_random(input int unsigned count);
    code_row_t   row;
    int unsigned r;
    repeat (count) begin
      r   = $urandom_range(99);
      row = '0;
      if (r < 4) begin
        row.start = 1'b1;
        row.code  = ($urandom_range(3) == 0)
                    ? lzwd_pkg::CODE_W'($urandom_range(4095, lzwd_pkg::LIT_NUM))
                    : lzwd_pkg::CODE_W'($urandom_range(lzwd_pkg::LIT_NUM - 1));
      end else if (r < 10) begin
        row.code = lzwd_pkg::CODE_W'($urandom);
      end else if (!prev_valid || r < 40) begin
        row.code = lzwd_pkg::CODE_W'($urandom_range(lzwd_pkg::LIT_NUM - 1));
      end else if (r < 60 && dict_next < 13'(TABLE_DEPTH)) begin
        row.code = dict_next[lzwd_pkg::CODE_W-1:0];
      end else if (dict_next > 13'(lzwd_pkg::LIT_NUM)) begin
        row.code = lzwd_pkg::CODE_W'($urandom_range(dict_next - 1, lzwd_pkg::LIT_NUM));
      end else begin
        row.code = lzwd_pkg::CODE_W'($urandom_range(lzwd_pkg::LIT_NUM - 1));
      end
      offer_code(row);
    end
  endtask

  // max_code only changes with nothing in flight
  task automatic write_limit(input logic [lzwd_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    dict_limit = v;
  endtask

  // receiver: check each taken byte, then pick the next stall
  initial begin
    dec_byte_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall) begin
        bytes_seen++;
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual byte %h last %b error %b",
                   $time, out_byte_o, last_o, error_o);
          fails++;
        end else begin
          e = pending_bytes.pop_front();
          if (out_byte_o !== e.value) begin
            $display("%0t: byte mismatch, expected %h actual %h", $time, e.value, out_byte_o);
            fails++;
          end
          if (last_o !== e.last) begin
            $display("%0t: last mismatch, expected %b actual %b", $time, e.last, last_o);
            fails++;
          end
          if (error_o !== e.err) begin
            $display("%0t: error mismatch, expected %b actual %b", $time, e.err, error_o);
            fails++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        // long hold-off so the decoder backs up into its input
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: run timed out after %0d cycles", $time, cycle_cnt);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    code_row_t row;
    dir_rows = '{
      '{12'd256,  1'b0, 1'b1, 8'h00, 1'b1},  // first code of a stream not a literal
      '{12'd0,    1'b1, 1'b1, 8'h80, 1'b0},
      '{12'd255,  1'b0, 1'b1, 8'h7f, 1'b0},
      '{12'd127,  1'b0, 1'b1, 8'hff, 1'b0},
      '{12'd128,  1'b0, 1'b1, 8'h00, 1'b0},
      '{12'd256,  1'b0, 1'b0, 8'h00, 1'b0},
      '{12'd260,  1'b0, 1'b0, 8'h00, 1'b0},  // next free code
      '{12'd262,  1'b0, 1'b1, 8'h00, 1'b1},  // beyond the next free code
      '{12'd4095, 1'b0, 1'b1, 8'h00, 1'b1},
      '{12'd261,  1'b0, 1'b0, 8'h00, 1'b0},
      '{12'd259,  1'b0, 1'b0, 8'h00, 1'b0},
      '{12'd300,  1'b1, 1'b1, 8'h00, 1'b1},
      '{12'd4095, 1'b1, 1'b1, 8'h00, 1'b1},
      '{12'd170,  1'b0, 1'b1, 8'h2a, 1'b0},
      '{12'd85,   1'b0, 1'b1, 8'hd5, 1'b0},
      '{12'd256,  1'b0, 1'b0, 8'h00, 1'b0},
      '{12'd258,  1'b0, 1'b0, 8'h00, 1'b0},
      '{12'd2048, 1'b0, 1'b1, 8'h00, 1'b1},
      '{12'd1,    1'b0, 1'b1, 8'h81, 1'b0},
      '{12'd254,  1'b1, 1'b1, 8'h7e, 1'b0}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) offer_code(dir_rows[i]);

    // smallest table: one entry per stream at most
    write_limit(lzwd_pkg::CFG_W'(lzwd_pkg::LIT_NUM));
    send_random(20);

    // full table, with a growing kwkwk chain that runs past MAX_RUN
    write_limit(lzwd_pkg::CFG_RST);
    hold_req = 1'b1;
    row       = '0;
    row.start = 1'b1;
    row.code  = lzwd_pkg::CODE_W'($urandom_range(lzwd_pkg::LIT_NUM - 1));
    offer_code(row);
    row.start = 1'b0;
    repeat (MAX_RUN + 1) begin
      row.code = dict_next[lzwd_pkg::CODE_W-1:0];
      offer_code(row);
    end
    idle_pct = 0;
    send_random(20);
    idle_pct = 7;

    // lowered limit, existing entries stay usable
    mid_limit = lzwd_pkg::CFG_W'($urandom_range(600, lzwd_pkg::LIT_NUM + 1));
    write_limit(mid_limit);
    send_random(25);

    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("covered %0d codes, %0d bytes taken, %0d undefined codes, %0d cut strings",
             codes_sent, bytes_seen, bad_codes, cut_strings);
    $display("max_code settings: reset, %0d, %0d, %0d", lzwd_pkg::LIT_NUM,
             lzwd_pkg::CFG_RST, mid_limit);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
